/* rtl/gbde_pkg.sv */
`timescale 1ns / 1ps

package gbde_pkg;

	// graph size and field widths
	localparam int NODES      = 16;
	localparam int NODE_W     = 4;
	localparam int DEG_W      = NODE_W + 1;
	localparam int WORK_DEPTH = 16;
	localparam int PTR_W      = 5;
	localparam int ADDR_W     = 2 * NODE_W;

	typedef logic [1:0]        cmd_t;
	typedef logic [1:0]        status_t;
	typedef logic [NODE_W-1:0] node_t;

	// command codes
	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_BFS    = 2'd1;
	localparam cmd_t CMD_DFS    = 2'd2;

	// result status codes
	localparam status_t STAT_ADDED = 2'd0;
	localparam status_t STAT_DUP   = 2'd1;
	localparam status_t STAT_VISIT = 2'd2;
	localparam status_t STAT_BAD   = 2'd3;

endpackage

/* rtl/graph_bfs_dfs_engine_core.sv */
`timescale 1ns / 1ps

// Directed-graph store with breadth-first and depth-first walks. Edges live in
// a single-port neighbor memory (one row per source node, kept in insertion
// order) and every stored edge is reached through that one port by a small
// sequencer, each edge read and then compared. Stalls on the output side can
// hold up a walk. The block takes one transaction at a time (in_stall is high
// while a command runs), but the next command may enter while the final result
// still waits at the output. Each walk clears all visited marks at once; the
// neighbor memory needs no clearing because only entries below a row's degree
// are ever read. Every insert or walk command gives one or more results with
// last set on the final one; command 3 is accepted and ignored.
module graph_bfs_dfs_engine_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gbde_pkg::cmd_t    command,
	input  gbde_pkg::node_t   from_node,
	input  gbde_pkg::node_t   to_node,
	input  gbde_pkg::node_t   start_node,
	input  gbde_pkg::node_t   node_count,
	output logic              out_valid,
	input  logic              out_stall,
	output gbde_pkg::status_t status,
	output gbde_pkg::node_t   visited_node,
	output logic              last
);
	import gbde_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_INS_RD  = 7'b0000010,
		ST_INS_CMP = 7'b0000100,
		ST_W_POP   = 7'b0001000,
		ST_W_RD    = 7'b0010000,
		ST_W_CHK   = 7'b0100000,
		ST_FIN     = 7'b1000000
	} state_t;

	state_t            state_q;
	node_t             row_q;
	node_t             to_q;
	logic [DEG_W-1:0]  cnt_q;
	logic [DEG_W-1:0]  idx_q;
	logic              dfs_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [DEG_W-1:0]  deg_q [NODES];
	logic [NODES-1:0]  visited_q;
	node_t             work_q [WORK_DEPTH];
	node_t             nbr_mem [NODES*NODES];
	node_t             rd_q;

	logic              hold_valid_q;
	status_t           hold_status_q;
	node_t             hold_node_q;
	logic              out_valid_q;
	status_t           out_status_q;
	node_t             out_node_q;
	logic              out_last_q;

	logic              out_free;
	logic              emit_ok;
	logic              emit_req;
	logic              emit_go;
	status_t           emit_status;
	node_t             emit_node;
	logic              fin_go;
	logic              start_bad;
	logic              edge_bad;
	logic              can_push;
	logic              stack_empty;
	logic              queue_empty;
	logic [PTR_W-1:0]  pop_ptr;
	node_t             pop_node;
	node_t             deg_sel;
	logic [DEG_W-1:0]  deg_rd;
	logic              mem_re;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_raddr;
	logic [ADDR_W-1:0] mem_waddr;

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign visited_node = out_node_q;
	assign last         = out_last_q;

	// handshake and decode helpers
	assign out_free    = !out_valid_q || !out_stall;
	assign emit_ok     = !hold_valid_q || out_free;
	assign start_bad   = (start_node > node_count) || ({1'b0, start_node} >= DEG_W'(NODES));
	assign edge_bad    = ({1'b0, from_node} >= DEG_W'(NODES)) ||
	                     ({1'b0, to_node} >= DEG_W'(NODES));
	assign stack_empty = (tail_q == '0);
	assign queue_empty = (head_q >= tail_q);
	assign pop_ptr     = dfs_q ? (tail_q - PTR_W'(1)) : head_q;
	assign pop_node    = work_q[pop_ptr[NODE_W-1:0]];
	assign can_push    = !visited_q[rd_q] && (tail_q < PTR_W'(WORK_DEPTH));
	assign deg_sel     = (state_q == ST_IDLE) ? from_node : pop_node;
	assign deg_rd      = deg_q[deg_sel];

	// neighbor memory port control
	assign mem_re    = ((state_q == ST_INS_RD) || (state_q == ST_W_RD)) && (idx_q != cnt_q);
	assign mem_raddr = {row_q, idx_q[NODE_W-1:0]};
	assign mem_we    = (state_q == ST_INS_RD) && (idx_q == cnt_q) && (cnt_q < DEG_W'(NODES));
	assign mem_waddr = {row_q, cnt_q[NODE_W-1:0]};

	// result generation
	always_comb begin
		emit_req    = 1'b0;
		emit_status = STAT_ADDED;
		emit_node   = '0;
		fin_go      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (command)
						CMD_INSERT: begin
							if (edge_bad) begin
								emit_req    = 1'b1;
								emit_status = STAT_DUP;
							end
						end
						CMD_BFS, CMD_DFS: begin
							if (start_bad) begin
								emit_req    = 1'b1;
								emit_status = STAT_BAD;
							end else if (command == CMD_BFS) begin
								emit_req    = 1'b1;
								emit_status = STAT_VISIT;
								emit_node   = start_node;
							end
						end
						default: ;
					endcase
				end
			end
			ST_INS_RD: begin
				if (idx_q == cnt_q) begin
					emit_req    = 1'b1;
					emit_status = STAT_ADDED;
				end
			end
			ST_INS_CMP: begin
				if (rd_q == to_q) begin
					emit_req    = 1'b1;
					emit_status = STAT_DUP;
				end
			end
			ST_W_POP: begin
				if (dfs_q && !stack_empty) begin
					emit_req    = 1'b1;
					emit_status = STAT_VISIT;
					emit_node   = pop_node;
				end
			end
			ST_W_CHK: begin
				if (!dfs_q && can_push) begin
					emit_req    = 1'b1;
					emit_status = STAT_VISIT;
					emit_node   = rd_q;
				end
			end
			ST_FIN: fin_go = out_free;
			default: ;
		endcase
		emit_go = emit_req && emit_ok;
	end

	// neighbor memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			nbr_mem[mem_waddr] <= to_q;
		end
		if (mem_re) begin
			rd_q <= nbr_mem[mem_raddr];
		end
	end

	// work list, no reset needed: read only below the tail
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid && !start_bad &&
		    ((command == CMD_BFS) || (command == CMD_DFS))) begin
			work_q[0] <= start_node;
		end else if ((state_q == ST_W_CHK) && can_push && (dfs_q || emit_ok)) begin
			work_q[tail_q[NODE_W-1:0]] <= rd_q;
		end
	end

	// result holding stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_go && hold_valid_q) begin
				out_valid_q  <= 1'b1;
				out_status_q <= hold_status_q;
				out_node_q   <= hold_node_q;
				out_last_q   <= 1'b0;
			end else if (fin_go) begin
				out_valid_q  <= 1'b1;
				out_status_q <= hold_status_q;
				out_node_q   <= hold_node_q;
				out_last_q   <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit_go) begin
				hold_valid_q  <= 1'b1;
				hold_status_q <= emit_status;
				hold_node_q   <= emit_node;
			end else if (fin_go) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			visited_q <= '0;
			dfs_q     <= 1'b0;
			for (int i = 0; i < NODES; i++) begin
				deg_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (command)
							CMD_INSERT: begin
								row_q <= from_node;
								to_q  <= to_node;
								cnt_q <= deg_rd;
								idx_q <= '0;
								state_q <= edge_bad ? ST_FIN : ST_INS_RD;
							end
							CMD_BFS, CMD_DFS: begin
								if (start_bad) begin
									state_q <= ST_FIN;
								end else begin
									// only the start node is marked
									visited_q <= NODES'(1) << start_node;
									head_q  <= '0;
									tail_q  <= PTR_W'(1);
									dfs_q   <= (command == CMD_DFS);
									state_q <= ST_W_POP;
								end
							end
							default: ;
						endcase
					end
				end
				ST_INS_RD: begin
					if (idx_q == cnt_q) begin
						if (cnt_q < DEG_W'(NODES)) begin
							deg_q[row_q] <= cnt_q + DEG_W'(1);
						end
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (rd_q == to_q) begin
						state_q <= ST_FIN;
					end else begin
						idx_q   <= idx_q + DEG_W'(1);
						state_q <= ST_INS_RD;
					end
				end
				ST_W_POP: begin
					if (dfs_q ? stack_empty : queue_empty) begin
						state_q <= ST_FIN;
					end else if (!dfs_q || emit_ok) begin
						if (dfs_q) begin
							tail_q <= pop_ptr;
						end else begin
							head_q <= head_q + PTR_W'(1);
						end
						row_q   <= pop_node;
						cnt_q   <= deg_rd;
						idx_q   <= '0;
						state_q <= ST_W_RD;
					end
				end
				ST_W_RD: begin
					state_q <= (idx_q == cnt_q) ? ST_W_POP : ST_W_CHK;
				end
				ST_W_CHK: begin
					// breadth-first push waits until the result can be queued
					if (!can_push || dfs_q || emit_ok) begin
						if (can_push) begin
							tail_q          <= tail_q + PTR_W'(1);
							visited_q[rd_q] <= 1'b1;
						end
						idx_q   <= idx_q + DEG_W'(1);
						state_q <= ST_W_RD;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// no pending result is left behind when a new command can enter
	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_valid_q)
		else $error("pending result left at idle");

	// the work list never grows past its depth
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= PTR_W'(WORK_DEPTH))
		else $error("work list overflow");

	// finishing a command presents its final result
	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_valid && last))
		else $error("final result missing last");

	// a displaced held result goes out as a non-final result
	a_emit_push: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && hold_valid_q) |=> (out_valid && !last))
		else $error("intermediate result lost");
`endif

endmodule

/* tb/sv/graph_walk_checker.sv */
`timescale 1ns / 1ps

module graph_walk_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  gbde_pkg::cmd_t    command,
	input  gbde_pkg::node_t   from_node,
	input  gbde_pkg::node_t   to_node,
	input  gbde_pkg::node_t   start_node,
	input  gbde_pkg::node_t   node_count,
	input  logic              out_valid,
	input  logic              out_stall,
	input  gbde_pkg::status_t status,
	input  gbde_pkg::node_t   visited_node,
	input  logic              last,
	output int                fail_count,
	output int                results_due
);
	import gbde_pkg::*;

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		status_t status;
		node_t   node;
		logic    last;
	} walk_result_t;

	// shadow copy of the graph and the walk scratch state
	node_t        adj [NODES][NODES];
	int unsigned  degree [NODES];
	logic         seen [NODES];
	node_t        work [WORK_DEPTH];
	int unsigned  head;
	int unsigned  tail;

	walk_result_t due_results [$];

	// append one command's results, last set on the final one
	task automatic queue_batch(ref walk_result_t batch [$]);
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		foreach (batch[i])
			due_results.push_back(batch[i]);
	endtask

	// breadth-first or depth-first walk over the shadow graph
	task automatic walk_graph(input bit depth_first, input node_t start);
		walk_result_t batch [$];
		node_t        cur;
		node_t        nb;
		bit           done;
		for (int k = 0; k < NODES; k++)
			seen[k] = 1'b0;
		head = 0;
		tail = 0;
		seen[start] = 1'b1;
		work[tail] = start;
		tail++;
		if (!depth_first)
			batch.push_back('{STAT_VISIT, start, 1'b0});
		done = 1'b0;
		while (!done) begin
			if (depth_first) begin
				if (tail == 0) begin
					done = 1'b1;
				end else begin
					tail--;
					cur = work[tail];
					if (batch.size() < WORK_DEPTH)
						batch.push_back('{STAT_VISIT, cur, 1'b0});
				end
			end else begin
				if (head >= tail) begin
					done = 1'b1;
				end else begin
					cur = work[head];
					head++;
				end
			end
			if (!done) begin
				for (int i = 0; i < degree[cur]; i++) begin
					nb = adj[cur][i];
					// already seen, or no room left on the work list
					if (!seen[nb] && tail < WORK_DEPTH) begin
						work[tail] = nb;
						tail++;
						seen[nb] = 1'b1;
						if (!depth_first && batch.size() < WORK_DEPTH)
							batch.push_back('{STAT_VISIT, nb, 1'b0});
					end
				end
			end
		end
		queue_batch(batch);
	endtask

	// expected results of one accepted transaction
	task automatic predict_command(input cmd_t cmd, input node_t src, input node_t dst,
			input node_t start, input node_t limit);
		walk_result_t batch [$];
		bit           dup;
		case (cmd)
			CMD_INSERT: begin
				dup = 1'b0;
				for (int i = 0; i < degree[src]; i++)
					if (adj[src][i] == dst)
						dup = 1'b1;
				if (!dup && degree[src] < NODES) begin
					adj[src][degree[src]] = dst;
					degree[src]++;
				end
				batch.push_back('{dup ? STAT_DUP : STAT_ADDED, node_t'(0), 1'b0});
				queue_batch(batch);
			end
			CMD_BFS, CMD_DFS: begin
				if (start > limit) begin
					batch.push_back('{STAT_BAD, node_t'(0), 1'b0});
					queue_batch(batch);
				end else begin
					walk_graph(cmd == CMD_DFS, start);
				end
			end
			default: ; // unused code: accepted, no result
		endcase
	endtask

	// compare outputs first, then record the new transaction
	always @(posedge clk or negedge arst_n) begin
		walk_result_t want;
		if (!arst_n) begin
			for (int k = 0; k < NODES; k++) begin
				degree[k] = 0;
				seen[k]   = 1'b0;
			end
			head = 0;
			tail = 0;
			due_results.delete();
			fail_count  <= 0;
			results_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("%0t: unexpected result status %0d node %0d last %0b",
							$realtime, status, visited_node, last);
					fail_count <= fail_count + 1;
				end else begin
					want = due_results.pop_front();
					if (status !== want.status || visited_node !== want.node ||
							last !== want.last) begin
						if (fail_count < REPORT_MAX)
							$display({"%0t: result mismatch: expected status %0d node %0d ",
								"last %0b, got status %0d node %0d last %0b"}, $realtime,
								want.status, want.node, want.last, status, visited_node, last);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_command(command, from_node, to_node, start_node, node_count);
			results_due <= due_results.size();
		end
	end

endmodule

/* tb/sv/tb_graph_bfs_dfs_engine_core.sv */
`timescale 1ns / 1ps

module tb_graph_bfs_dfs_engine_core;
	import gbde_pkg::*;

	localparam cmd_t CMD_UNUSED   = 2'd3;
	localparam int   RANDOM_ITEMS = 340;
	localparam int   IDLE_LIMIT   = 5000;
	localparam int   DRAIN_CYCLES = 600;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	cmd_t    command;
	node_t   from_node;
	node_t   to_node;
	node_t   start_node;
	node_t   node_count;
	logic    out_valid;
	logic    out_stall;
	status_t status;
	node_t   visited_node;
	logic    last;
	int      fail_count;
	int      results_due;
	int      burst_left;

	graph_bfs_dfs_engine_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.from_node    (from_node),
		.to_node      (to_node),
		.start_node   (start_node),
		.node_count   (node_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.visited_node (visited_node),
		.last         (last)
	);

	graph_walk_checker walk_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.from_node    (from_node),
		.to_node      (to_node),
		.start_node   (start_node),
		.node_count   (node_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.visited_node (visited_node),
		.last         (last),
		.fail_count   (fail_count),
		.results_due  (results_due)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one command transaction, sent in bursts with random gaps between them
	task automatic send_command(input cmd_t cmd, input node_t src, input node_t dst,
			input node_t start, input node_t limit);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		command    <= cmd;
		from_node  <= src;
		to_node    <= dst;
		start_node <= start;
		node_count <= limit;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// hold off until every outstanding result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (results_due != 0)
			@(negedge clk);
	endtask

	// receiver stall pattern: free-running, light and heavy stretches
	initial begin
		int mode;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(5, 60)) begin
				@(negedge clk);
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("FAILURE");
		$finish;
	end

	// stimulus and verdict
	initial begin
		int    sent;
		int    pick;
		bit    paused;
		cmd_t  cmd;
		node_t src;
		node_t dst;
		node_t start;
		node_t limit;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		command    = CMD_INSERT;
		from_node  = '0;
		to_node    = '0;
		start_node = '0;
		node_count = '0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walks on the empty graph, invalid starts
		send_command(CMD_BFS,    4'd0,  4'd0,  4'd0,  4'd0);
		send_command(CMD_DFS,    4'd15, 4'd15, 4'd15, 4'd15);
		send_command(CMD_BFS,    4'd0,  4'd0,  4'd6,  4'd5);
		send_command(CMD_DFS,    4'd0,  4'd0,  4'd15, 4'd0);
		// inserts at the extremes, duplicate, self loops
		send_command(CMD_INSERT, 4'd0,  4'd15, 4'd0,  4'd0);
		send_command(CMD_INSERT, 4'd0,  4'd15, 4'd0,  4'd0);
		send_command(CMD_INSERT, 4'd15, 4'd0,  4'd0,  4'd0);
		send_command(CMD_INSERT, 4'd5,  4'd5,  4'd0,  4'd0);
		send_command(CMD_INSERT, 4'd0,  4'd0,  4'd0,  4'd0);
		send_command(CMD_INSERT, 4'd0,  4'd1,  4'd0,  4'd0);
		send_command(CMD_INSERT, 4'd1,  4'd9,  4'd0,  4'd0);
		send_command(CMD_INSERT, 4'd9,  4'd2,  4'd0,  4'd0);
		// unused command is swallowed
		send_command(CMD_UNUSED, 4'd15, 4'd15, 4'd15, 4'd15);
		// neighbors above node_count are still visited
		send_command(CMD_BFS,    4'd0,  4'd0,  4'd0,  4'd0);
		send_command(CMD_DFS,    4'd0,  4'd0,  4'd0,  4'd3);
		send_command(CMD_DFS,    4'd0,  4'd0,  4'd5,  4'd5);
		send_command(CMD_INSERT, 4'd15, 4'd7,  4'd0,  4'd0);
		send_command(CMD_INSERT, 4'd7,  4'd3,  4'd0,  4'd0);
		send_command(CMD_BFS,    4'd0,  4'd0,  4'd15, 4'd15);
		send_command(CMD_DFS,    4'd0,  4'd0,  4'd15, 4'd15);
		send_command(CMD_BFS,    4'd0,  4'd0,  4'd9,  4'd15);

		// random part: short chains first, then arbitrary edges
		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (!paused && sent == RANDOM_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			src  = node_t'($urandom);
			dst  = node_t'($urandom);
			if (pick < 3) begin
				send_command(CMD_UNUSED, src, dst, node_t'($urandom), node_t'($urandom));
			end else begin
				if (pick < 58) begin
					cmd   = CMD_INSERT;
					start = node_t'($urandom);
					limit = node_t'($urandom);
					if (sent < RANDOM_ITEMS / 2 && $urandom_range(0, 4) != 0)
						dst = node_t'(src + $urandom_range(1, 3));
				end else begin
					cmd = (pick < 79) ? CMD_BFS : CMD_DFS;
					if ($urandom_range(0, 6) != 0) begin
						start = node_t'($urandom);
						limit = node_t'($urandom_range(start, 15));
					end else begin
						start = node_t'($urandom_range(1, 15));
						limit = node_t'($urandom_range(0, start - 1));
					end
				end
				send_command(cmd, src, dst, start, limit);
				sent++;
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then give a late or spurious result time to show up
		while (results_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
